// File: sv/bfop_pkg.sv
package bfop_pkg;

   // Field widths fixed by the item format.
   localparam int CNT_W   = 13;
   localparam int ADDR_W  = 12;
   localparam int KIND_W  = 3;
   localparam int VALUE_W = 16;
   localparam int BYTE_W  = 8;

   // Item operation codes.
   localparam logic OPERATION_LOAD = 1'b0;
   localparam logic OPERATION_STEP = 1'b1;

   // Program operation kinds.
   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INPUT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OUTPUT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd6;

   // One program word as held in the program store.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
   } prog_word_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MOVE
   } seq_state_type;

endpackage

// File: sv/bf_op_execution_core.sv
// A request transfer captures the item, the program word and the tape cell; the execute
// state, once the response register is free, writes back the tape cell and loads the
// registered response. No new item is taken until the last is through, and a pointer move
// adds a move state in which wraps are corrected. Reset: synchronous, active high; afterwards
// the tape is cleared one cell per cycle, and no request is taken until the clear is done (CSR writes still are).
module bf_op_execution_core #(
   parameter int PROG_DEPTH = 4096,
   parameter int TAPE_DEPTH = 32768
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration port
   input  logic                                  csr_write_enable,
   input  logic [bfop_pkg::CNT_W-1:0]            csr_write_data,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [bfop_pkg::ADDR_W-1:0]           req_word_address,
   input  logic [bfop_pkg::KIND_W-1:0]           req_op_kind,
   input  logic signed [bfop_pkg::VALUE_W-1:0]   req_op_value,
   input  logic [bfop_pkg::BYTE_W-1:0]           req_in_byte,
   input  logic                                  req_in_valid,
   // Response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bfop_pkg::BYTE_W-1:0]           rsp_out_byte,
   output logic                                  rsp_out_valid,
   output logic                                  rsp_byte_consumed,
   output logic                                  rsp_needs_input,
   output logic                                  rsp_halted,
   output logic [bfop_pkg::CNT_W-1:0]            rsp_counter_now
);
   import bfop_pkg::*;

   localparam int PA_W = $clog2(PROG_DEPTH);
   localparam int TW   = $clog2(TAPE_DEPTH);
   localparam int PCW  = PA_W + CNT_W;
   localparam int LAW  = PA_W + ADDR_W;
   // Signed pointer sum wide enough for any pointer plus any move distance.
   localparam int SW   = ((TW > VALUE_W) ? TW : VALUE_W) + 2;
   localparam logic signed [SW-1:0] TAPE_LIMIT = SW'(TAPE_DEPTH);
   localparam logic [TW-1:0]        PTR_RESET  = TW'(TAPE_DEPTH / 2);
   localparam logic [TW-1:0]        CLR_LAST   = TW'(TAPE_DEPTH - 1);

   // Memories.
   prog_word_type       prog_mem [PROG_DEPTH];
   logic [BYTE_W-1:0]   tape_mem [TAPE_DEPTH];

   // Sequencer and architectural state.
   seq_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         pc_ff, pc_in;
   logic [VALUE_W-1:0]       rep_ff, rep_in;
   logic [TW-1:0]            ptr_ff;
   logic [TW-1:0]            clr_ff;
   logic signed [SW-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]         len_ff;

   // Captured request item.
   logic                     operation_ff;
   logic [ADDR_W-1:0]        addr_ff;
   prog_word_type            load_word_ff;
   logic [BYTE_W-1:0]        in_byte_ff;
   logic                     in_valid_ff;

   // Registered memory read data.
   prog_word_type            prog_rd_ff;
   logic [BYTE_W-1:0]        tape_rd_ff;

   // Response register.
   logic                     rsp_valid_ff;
   logic [BYTE_W-1:0]        out_byte_ff, out_byte_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     consumed_ff, consumed_in;
   logic                     needs_ff, needs_in;
   logic                     halted_ff, halted_in;

   // Control.
   logic                     accept;
   logic                     exec_go;
   logic                     clr_done;
   logic                     move_start;
   logic                     move_done;
   logic                     halted_cur;
   logic                     step_live;
   logic                     tape_we;
   logic [TW-1:0]            tape_wa;
   logic [BYTE_W-1:0]        tape_wd;
   logic [BYTE_W-1:0]        exec_wd;
   logic                     exec_we;
   logic                     prog_we;
   logic [PA_W-1:0]          prog_rd_addr;
   logic [PA_W-1:0]          prog_wr_addr;
   logic [PCW-1:0]           pc_wide;
   logic [LAW-1:0]           load_wide;
   logic                     load_in_range;
   logic [VALUE_W-1:0]       rem;
   logic                     nonpos;
   logic                     sum_neg;
   logic                     sum_high;
   logic signed [SW-1:0]     sum_fix;

   // Program store addressing from the counter and the load address.
   assign pc_wide       = PCW'(pc_ff);
   assign prog_rd_addr  = pc_wide[PA_W-1:0];
   assign load_wide     = LAW'(addr_ff);
   assign prog_wr_addr  = load_wide[PA_W-1:0];
   assign load_in_range = 32'(addr_ff) < 32'(PROG_DEPTH);

   assign halted_cur = (pc_ff >= len_ff) || (32'(pc_ff) >= 32'(PROG_DEPTH));
   assign clr_done   = (clr_ff == CLR_LAST);

   // Pointer wrap correction, one add or subtract of the tape depth per cycle.
   assign sum_neg   = sum_ff < 0;
   assign sum_high  = sum_ff >= TAPE_LIMIT;
   assign move_done = !sum_neg && !sum_high;
   assign sum_fix   = sum_neg ? (sum_ff + TAPE_LIMIT) : (sum_ff - TAPE_LIMIT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_go) state_in = move_start ? ST_MOVE : ST_IDLE;
         end
         ST_MOVE: begin
            if (move_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      exec_go   = 1'b0;
      tape_we   = 1'b0;
      tape_wa   = ptr_ff;
      tape_wd   = exec_wd;
      prog_we   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            tape_we = 1'b1;
            tape_wa = clr_ff;
            tape_wd = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_EXEC: begin
            exec_go = !rsp_valid_ff || !rsp_stall;
            tape_we = exec_go && exec_we;
            prog_we = exec_go && (operation_ff == OPERATION_LOAD) && load_in_range;
         end
         ST_MOVE: begin
         end
         default: begin
         end
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign step_live = (operation_ff == OPERATION_STEP) && !halted_cur;

   // Execution of one step on the fetched word and cell.
   always_comb begin
      pc_in        = pc_ff;
      rep_in       = rep_ff;
      exec_we      = 1'b0;
      exec_wd      = tape_rd_ff;
      out_byte_in  = '0;
      out_valid_in = 1'b0;
      consumed_in  = 1'b0;
      needs_in     = 1'b0;
      move_start   = 1'b0;
      rem          = ((rep_ff != '0) ? rep_ff : prog_rd_ff.value) - VALUE_W'(1);
      nonpos       = prog_rd_ff.value[VALUE_W-1] || (prog_rd_ff.value == '0);
      sum_in       = $signed({{(SW-TW){1'b0}}, ptr_ff})
                   + $signed({{(SW-VALUE_W){prog_rd_ff.value[VALUE_W-1]}},
                              prog_rd_ff.value});
      if (step_live) begin
         case (prog_rd_ff.kind)
            KIND_ADD: begin
               exec_we = 1'b1;
               exec_wd = tape_rd_ff + prog_rd_ff.value[BYTE_W-1:0];
               pc_in   = pc_ff + CNT_W'(1);
            end
            KIND_SET: begin
               exec_we = 1'b1;
               exec_wd = prog_rd_ff.value[BYTE_W-1:0];
               pc_in   = pc_ff + CNT_W'(1);
            end
            KIND_MOVE: begin
               move_start = 1'b1;
               pc_in      = pc_ff + CNT_W'(1);
            end
            KIND_INPUT: begin
               if (rep_ff == '0 && nonpos) begin
                  pc_in = pc_ff + CNT_W'(1);
               end else if (in_valid_ff) begin
                  exec_we     = 1'b1;
                  exec_wd     = in_byte_ff;
                  consumed_in = 1'b1;
                  rep_in      = rem;
                  if (rem == '0) pc_in = pc_ff + CNT_W'(1);
               end else begin
                  needs_in = 1'b1;
               end
            end
            KIND_OUTPUT: begin
               if (rep_ff == '0 && nonpos) begin
                  pc_in = pc_ff + CNT_W'(1);
               end else begin
                  out_byte_in  = tape_rd_ff;
                  out_valid_in = 1'b1;
                  rep_in       = rem;
                  if (rem == '0) pc_in = pc_ff + CNT_W'(1);
               end
            end
            KIND_OPEN: begin
               if (tape_rd_ff == '0) pc_in = prog_rd_ff.value[CNT_W-1:0] + CNT_W'(1);
               else                  pc_in = pc_ff + CNT_W'(1);
            end
            KIND_CLOSE: begin
               if (tape_rd_ff != '0) pc_in = prog_rd_ff.value[CNT_W-1:0] + CNT_W'(1);
               else                  pc_in = pc_ff + CNT_W'(1);
            end
            default: pc_in = pc_ff + CNT_W'(1);
         endcase
      end
      halted_in = (pc_in >= len_ff) || (32'(pc_in) >= 32'(PROG_DEPTH));
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         rep_ff       <= '0;
         ptr_ff       <= PTR_RESET;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + TW'(1);
         if (csr_write_enable) len_ff <= csr_write_data;
         if (exec_go) begin
            pc_ff  <= pc_in;
            rep_ff <= rep_in;
         end
         if (state_ff == ST_MOVE && move_done) ptr_ff <= sum_ff[TW-1:0];
         if (exec_go)         rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         operation_ff       <= req_operation;
         addr_ff            <= req_word_address;
         load_word_ff.kind  <= req_op_kind;
         load_word_ff.value <= req_op_value;
         in_byte_ff         <= req_in_byte;
         in_valid_ff        <= req_in_valid;
      end
      if (exec_go && move_start) sum_ff <= sum_in;
      else if (state_ff == ST_MOVE && !move_done) sum_ff <= sum_fix;
      if (exec_go) begin
         out_byte_ff  <= out_byte_in;
         out_valid_ff <= out_valid_in;
         consumed_ff  <= consumed_in;
         needs_ff     <= needs_in;
         halted_ff    <= halted_in;
      end
   end

   // Program store: written by load items, read at the counter on each transfer.
   always_ff @(posedge clock) begin
      if (prog_we) prog_mem[prog_wr_addr] <= load_word_ff;
      if (accept)  prog_rd_ff <= prog_mem[prog_rd_addr];
   end

   // Tape: cleared after reset, read at the pointer on each transfer, written back
   // in the execute cycle.
   always_ff @(posedge clock) begin
      if (tape_we) tape_mem[tape_wa] <= tape_wd;
      if (accept)  tape_rd_ff <= tape_mem[ptr_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_out_valid     = out_valid_ff;
   assign rsp_byte_consumed = consumed_ff;
   assign rsp_needs_input   = needs_ff;
   assign rsp_halted        = halted_ff;
   assign rsp_counter_now   = pc_ff;

endmodule

// File: verif/bf_op_execution_core_tb.sv
module bf_op_execution_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bfop_pkg::*;

   localparam int PROG_DEPTH    = 4096;
   localparam int TAPE_DEPTH    = 32768;
   // Largest program region used by the random rounds.
   localparam int REGION        = 64;
   localparam int ROUNDS        = 10;
   localparam int ROUND_ITEMS   = 85;
   localparam int SETTLE_CYCLES = 8;
   // No request is taken while the tape is cleared after reset, so the limit sits well above the tape depth.
   localparam int IDLE_LIMIT    = 100000;
   // Kind seven has no name in the package; it behaves as a no-operation.
   localparam logic [KIND_W-1:0] KIND_IDLE = 3'd7;

   typedef struct packed {
      logic               operation;
      logic [ADDR_W-1:0]  word_address;
      logic [KIND_W-1:0]  op_kind;
      logic [VALUE_W-1:0] op_value;
      logic [BYTE_W-1:0]  in_byte;
      logic               in_valid;
   } tape_request_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_valid;
      logic              byte_consumed;
      logic              needs_input;
      logic              halted;
      logic [CNT_W-1:0]  counter_now;
   } step_report_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [CNT_W-1:0]    csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_operation    = 1'b0;
   logic [ADDR_W-1:0]   req_word_address = '0;
   logic [KIND_W-1:0]   req_op_kind      = '0;
   logic signed [VALUE_W-1:0] req_op_value = '0;
   logic [BYTE_W-1:0]   req_in_byte      = '0;
   logic                req_in_valid     = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_out_valid;
   logic                rsp_byte_consumed;
   logic                rsp_needs_input;
   logic                rsp_halted;
   logic [CNT_W-1:0]    rsp_counter_now;

   // Tape machine state as the block should hold it.
   prog_word_type       program_image [PROG_DEPTH];
   bit [BYTE_W-1:0]     tape_image [TAPE_DEPTH];
   bit [CNT_W-1:0]      counter_model = '0;
   bit [CNT_W-1:0]      length_model  = '0;
   bit [14:0]           pointer_model = 15'(TAPE_DEPTH / 2);
   bit [VALUE_W-1:0]    repeat_model  = '0;

   step_report_type     pending_reports [$];

   int error_count    = 0;
   int checked_count  = 0;
   int load_count     = 0;
   int step_count     = 0;
   int emitted_count  = 0;
   int starved_count  = 0;
   int length_writes  = 0;
   int quiet_cycles   = 0;
   int stall_left     = 0;
   bit sender_quiet   = 1'b0;
   bit receiver_quiet = 1'b0;

   bf_op_execution_core #(
      .PROG_DEPTH (PROG_DEPTH),
      .TAPE_DEPTH (TAPE_DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_word_address  (req_word_address),
      .req_op_kind       (req_op_kind),
      .req_op_value      (req_op_value),
      .req_in_byte       (req_in_byte),
      .req_in_valid      (req_in_valid),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_byte_consumed (rsp_byte_consumed),
      .rsp_needs_input   (rsp_needs_input),
      .rsp_halted        (rsp_halted),
      .rsp_counter_now   (rsp_counter_now)
   );

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic bit machine_halted();
      return counter_model >= length_model || counter_model >= PROG_DEPTH;
   endfunction

   // A loop word that is certain to jump, given the cell the machine will see.
   function automatic logic [KIND_W-1:0] jump_kind();
      return (tape_image[pointer_model] == 0) ? KIND_OPEN : KIND_CLOSE;
   endfunction

   // Advances the machine by one transfer and queues the response it should give.
   task automatic run_tape_machine(input tape_request_type r);
      step_report_type  rep;
      prog_word_type    w;
      logic [BYTE_W-1:0] cell_value;
      logic [VALUE_W-1:0] left;
      rep = '0;
      if (r.operation == OPERATION_LOAD) begin
         program_image[r.word_address] = {r.op_kind, r.op_value};
         load_count++;
      end else begin
         step_count++;
         if (!machine_halted()) begin
            w = program_image[counter_model[ADDR_W-1:0]];
            cell_value = tape_image[pointer_model];
            case (w.kind)
               KIND_ADD: begin
                  tape_image[pointer_model] = cell_value + w.value[BYTE_W-1:0];
                  counter_model++;
               end
               KIND_SET: begin
                  tape_image[pointer_model] = w.value[BYTE_W-1:0];
                  counter_model++;
               end
               KIND_MOVE: begin
                  // The tape depth divides 2^16, so the low bits of the distance suffice.
                  pointer_model = pointer_model + w.value[14:0];
                  counter_model++;
               end
               KIND_INPUT, KIND_OUTPUT: begin
                  if (repeat_model == 0 && $signed(w.value) <= 0) begin
                     counter_model++;
                  end else if (w.kind == KIND_INPUT && !r.in_valid) begin
                     rep.needs_input = 1'b1;
                     starved_count++;
                  end else begin
                     if (w.kind == KIND_INPUT) begin
                        tape_image[pointer_model] = r.in_byte;
                        rep.byte_consumed = 1'b1;
                     end else begin
                        rep.out_byte  = cell_value;
                        rep.out_valid = 1'b1;
                        emitted_count++;
                     end
                     // A count already under way takes precedence over the word's count.
                     left = (repeat_model != 0) ? repeat_model : w.value;
                     repeat_model = left - 1'b1;
                     if (repeat_model == 0) counter_model++;
                  end
               end
               KIND_OPEN: begin
                  if (cell_value == 0) counter_model = w.value[CNT_W-1:0] + 1'b1;
                  else counter_model++;
               end
               KIND_CLOSE: begin
                  if (cell_value != 0) counter_model = w.value[CNT_W-1:0] + 1'b1;
                  else counter_model++;
               end
               default: begin
                  counter_model++;
               end
            endcase
         end
      end
      rep.halted      = machine_halted();
      rep.counter_now = counter_model;
      pending_reports.push_back(rep);
   endtask

   // Drives one request and returns at the edge where its transfer happens.
   task automatic send_item(input tape_request_type r);
      int gap;
      gap = sender_quiet ? 0 : pick_gap();
      if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
      run_tape_machine(r);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation    = r.operation;
      req_word_address = r.word_address;
      req_op_kind      = r.op_kind;
      req_op_value     = r.op_value;
      req_in_byte      = r.in_byte;
      req_in_valid     = r.in_valid;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the sender off until every response is in, then lets the pipeline settle.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_program_length(input int length);
      wait_for_results();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = CNT_W'(length);
      @(negedge clock);
      csr_write_enable = 1'b0;
      length_model = CNT_W'(length);
      length_writes++;
   endtask

   function automatic tape_request_type random_request();
      tape_request_type r;
      r.operation    = 1'($urandom_range(0, 1));
      r.word_address = ADDR_W'($urandom_range(0, PROG_DEPTH - 1));
      r.op_kind      = KIND_W'($urandom_range(0, 7));
      r.op_value     = VALUE_W'($urandom_range(0, 65535));
      r.in_byte      = BYTE_W'($urandom_range(0, 255));
      r.in_valid     = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic tape_request_type load_request(input int addr,
                                                     input logic [KIND_W-1:0] kind,
                                                     input logic [VALUE_W-1:0] value);
      tape_request_type r;
      r = random_request();
      r.operation    = OPERATION_LOAD;
      r.word_address = ADDR_W'(addr);
      r.op_kind      = kind;
      r.op_value     = value;
      return r;
   endfunction

   function automatic tape_request_type step_request(input logic in_valid,
                                                     input logic [BYTE_W-1:0] in_byte);
      tape_request_type r;
      r = random_request();
      r.operation = OPERATION_STEP;
      r.in_valid  = in_valid;
      r.in_byte   = in_byte;
      return r;
   endfunction

   // Bytes are offered on three steps out of four.
   function automatic tape_request_type random_step();
      return step_request($urandom_range(0, 3) != 0, BYTE_W'($urandom_range(0, 255)));
   endfunction

   // Random program word; inside the region, jumps land inside the region or at word zero.
   function automatic tape_request_type program_word(input int addr, input int len);
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      int                 roll;
      kind  = KIND_W'($urandom_range(0, 7));
      value = VALUE_W'($urandom_range(0, 65535));
      roll  = $urandom_range(0, 9);
      if (kind == KIND_INPUT || kind == KIND_OUTPUT) begin
         if (roll < 7) value = VALUE_W'($urandom_range(1, 4));
         else if (roll == 7) value = '0;
         else if (roll == 8) value = 16'hFFFF - VALUE_W'($urandom_range(0, 2));
         else value = 16'h8000;
      end else if ((kind == KIND_OPEN || kind == KIND_CLOSE) && addr < len) begin
         if (len >= 2 && roll < 8) value = VALUE_W'($urandom_range(0, len - 2));
         else value = 16'hFFFF;
      end
      return load_request(addr, kind, value);
   endfunction

   // Brings the counter back to word zero, then loads a fresh program of the given length.
   task automatic restart_program(input int len);
      if (counter_model != 0) begin
         if (machine_halted()) write_program_length(int'(counter_model) + 1);
         send_item(load_request(int'(counter_model), jump_kind(), 16'hFFFF));
         send_item(random_step());
      end
      write_program_length(len);
      for (int a = 0; a < len; a++) send_item(program_word(a, len));
   endtask

   // Every kind of operation but the loop close, the input stall, counts that do nothing, wrapping moves
   // and the jump whose target wraps to word zero.
   task automatic test_directed_program();
      write_program_length(0);
      send_item(step_request(1'b1, 8'h33));
      send_item(load_request(0, KIND_SET, 16'h1280));
      send_item(load_request(1, KIND_INPUT, 16'd2));
      send_item(load_request(2, KIND_OUTPUT, 16'h8000));
      send_item(load_request(3, KIND_OUTPUT, 16'd2));
      send_item(load_request(4, KIND_ADD, 16'hFF01));
      send_item(load_request(5, KIND_MOVE, 16'hBFFF));
      send_item(load_request(6, KIND_IDLE, 16'h7FFF));
      send_item(load_request(7, KIND_MOVE, 16'h0001));
      send_item(load_request(8, KIND_OPEN, 16'hFFFF));
      write_program_length(9);
      send_item(step_request(1'b1, 8'h11));
      send_item(step_request(1'b0, 8'hA5));
      send_item(step_request(1'b1, 8'h00));
      send_item(step_request(1'b1, 8'hFF));
      repeat (8) send_item(step_request(1'b0, 8'h00));
   endtask

   // Rounds of random programs; the last word is mostly turned into a jump back to the start.
   task automatic test_random_rounds();
      int len;
      int addr;
      for (int round = 0; round < ROUNDS; round++) begin
         if (round == 0 || round == 5) len = REGION;
         else if (round == 3) len = 1;
         else len = $urandom_range(2, REGION);
         restart_program(len);
         for (int n = 0; n < ROUND_ITEMS; n++) begin
            if (n == ROUND_ITEMS / 2) wait_for_results();
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 1) == 0) addr = $urandom_range(0, len - 1);
               else addr = $urandom_range(0, PROG_DEPTH - 1);
               send_item(program_word(addr, len));
            end else begin
               if (!machine_halted() && counter_model == len - 1 && $urandom_range(0, 9) != 0)
                  send_item(load_request(len - 1, jump_kind(), 16'hFFFF));
               send_item(random_step());
            end
         end
      end
   endtask

   // Full program length, the top of the store, and a counter sent past the store's end.
   task automatic test_store_end();
      write_program_length(PROG_DEPTH);
      send_item(load_request(int'(counter_model), jump_kind(), 16'd4093));
      send_item(random_step());
      send_item(load_request(PROG_DEPTH - 2, KIND_ADD, VALUE_W'($urandom_range(0, 65535))));
      send_item(random_step());
      send_item(load_request(PROG_DEPTH - 1, jump_kind(), 16'd6000));
      repeat (3) send_item(random_step());
      write_program_length(0);
      send_item(random_step());
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0h, expected %0h (response %0d)",
                                   name, got, want, checked_count));
   endtask

   // Each response transfer is compared with the oldest expectation.
   always @(posedge clock) begin : check_responses
      step_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected, counter %0d",
                                      rsp_counter_now));
         end else begin
            want = pending_reports.pop_front();
            check_field("out_byte", 16'(rsp_out_byte), 16'(want.out_byte));
            check_field("out_valid", 16'(rsp_out_valid), 16'(want.out_valid));
            check_field("byte_consumed", 16'(rsp_byte_consumed), 16'(want.byte_consumed));
            check_field("needs_input", 16'(rsp_needs_input), 16'(want.needs_input));
            check_field("halted", 16'(rsp_halted), 16'(want.halted));
            check_field("counter_now", 16'(rsp_counter_now), 16'(want.counter_now));
         end
         checked_count++;
      end
   end

   // Receiver back-pressure, with stretches where it never stalls.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
         if ($urandom_range(0, 299) == 0) receiver_quiet = !receiver_quiet;
         if (!receiver_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // Ends the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     IDLE_LIMIT, pending_reports.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_program();
      test_random_rounds();
      test_store_end();
      wait_for_results();
      $display("Ran %0d program loads and %0d steps; %0d bytes emitted, %0d input stalls.",
               load_count, step_count, emitted_count, starved_count);
      $display("%0d program length writes, %0d responses checked, %0d mismatches.",
               length_writes, checked_count, error_count);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// File: bf_op_execution_core.f
sv/bfop_pkg.sv
sv/bf_op_execution_core.sv
verif/bf_op_execution_core_tb.sv
